/* design/tzls_pkg.sv */
// ----------------------------------------------------------------------------
// Tuner zigzag lock search package
// Shared types, codes, timing constants and the symbol rate step helper.
// ----------------------------------------------------------------------------
package tzls_pkg;

  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned SR_W    = 27;
  localparam int unsigned FEC_W   = 4;
  localparam int unsigned INV_W   = 2;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned SRQ_W   = 14;
  localparam int unsigned OFF_W   = SRQ_W + STEP_W - 1;

  localparam int unsigned ZIGZAG_LIMIT = 20;

  // Symbol rate / 16000 is (rate >> 7) / 125, done with a rounded-up
  // reciprocal that is exact over the whole input range.
  localparam int unsigned SR_DIV_SHIFT   = 7;
  localparam int unsigned SR_RECIP_W     = 21;
  localparam int unsigned SR_RECIP_SHIFT = 27;
  localparam logic [SR_RECIP_W-1:0] SR_RECIP = 21'd1073742;

  localparam logic [DELAY_W-1:0] WAIT_IDLE      = 16'd1000;
  localparam logic [DELAY_W-1:0] WAIT_TUNE_SAT  = 16'd100;
  localparam logic [DELAY_W-1:0] WAIT_TUNE      = 16'd500;
  localparam logic [DELAY_W-1:0] WAIT_STEP_FAST = 16'd50;
  localparam logic [DELAY_W-1:0] WAIT_STEP      = 16'd500;
  localparam logic [DELAY_W-1:0] WAIT_DONE      = 16'd10000;
  localparam logic [DELAY_W-1:0] WAIT_RETUNE    = 16'd500;
  localparam logic [DELAY_W-1:0] WAIT_WATCH     = 16'd60000;
  localparam logic [DELAY_W-1:0] WAIT_NOW       = 16'd0;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_TUNE   = 2'd1,
    MODE_ZIGZAG = 2'd2,
    MODE_WATCH  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_TUNE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_WAKE = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SYS_SAT   = 2'd0,
    SYS_CABLE = 2'd1,
    SYS_TERR  = 2'd2,
    SYS_NONE  = 2'd3
  } sys_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DONE = 2'd1,
    EV_FAIL = 2'd2
  } event_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIVERY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST     = 1'b1;

  typedef struct packed {
    cmd_e              cmd;
    logic [FREQ_W-1:0] freq;
    logic [SR_W-1:0]   sr;
    logic [FEC_W-1:0]  fec;
    logic [INV_W-1:0]  inv;
    logic              lock_now;
    logic              lock_after;
  } in_item_t;

  typedef struct packed {
    logic               fv;
    logic [FREQ_W-1:0]  fval;
    logic               fe;
    logic               rst;
    event_e             ev;
    logic [FREQ_W-1:0]  evf;
    mode_e              mode;
    logic [DELAY_W-1:0] delay;
    logic [FREQ_W-1:0]  cur;
  } result_t;

  function automatic logic [SRQ_W-1:0] sr_step(input logic [SR_W-1:0] sr);
    logic [SR_W-SR_DIV_SHIFT-1:0]            y;
    logic [SR_W-SR_DIV_SHIFT+SR_RECIP_W-1:0] p;
    y = sr[SR_W-1:SR_DIV_SHIFT];
    p = {{SR_RECIP_W{1'b0}}, y} * {{(SR_W-SR_DIV_SHIFT){1'b0}}, SR_RECIP};
    return p[SR_RECIP_SHIFT +: SRQ_W];
  endfunction

endpackage

/* design/tzls_in_stage.sv */
// ----------------------------------------------------------------------------
// Tuner zigzag lock search input stage
// Registers one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tzls_in_stage
  import tzls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

/* design/tzls_out_stage.sv */
// ----------------------------------------------------------------------------
// Tuner zigzag lock search result stage
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tzls_out_stage
  import tzls_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    load_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign load_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      res_q <= res_i;
    end
  end

endmodule

/* design/tzls_core.sv */
// ----------------------------------------------------------------------------
// Tuner zigzag lock search core
// Holds the tuning state and turns one request into one result per cycle while advance_i is high.
// ----------------------------------------------------------------------------
module tzls_core
  import tzls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  advance_i,
  input  in_item_t              item_i,
  output result_t               res_o
);

  sys_e               sys_q;
  logic               fast_q;

  mode_e              mode_q, mode_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [FREQ_W-1:0]  act_f_q, act_f_d;
  logic [SR_W-1:0]    act_sr_q, act_sr_d;
  logic [SRQ_W-1:0]   act_srq_q, act_srq_d;
  logic [FEC_W-1:0]   act_fec_q, act_fec_d;
  logic [INV_W-1:0]   act_inv_q, act_inv_d;
  logic [FREQ_W-1:0]  pend_f_q, pend_f_d;
  logic [SR_W-1:0]    pend_sr_q, pend_sr_d;
  logic [SRQ_W-1:0]   pend_srq_q, pend_srq_d;
  logic [FEC_W-1:0]   pend_fec_q, pend_fec_d;
  logic [INV_W-1:0]   pend_inv_q, pend_inv_d;
  logic [FREQ_W-1:0]  tuned_q, tuned_d;
  logic [DELAY_W-1:0] wait_q, wait_d;

  logic               freq_chg;
  logic               front;
  logic [OFF_W-1:0]   off;
  logic [FREQ_W-1:0]  zz_freq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q  <= SYS_SAT;
      fast_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DELIVERY: sys_q  <= sys_e'(cfg_data_i);
        CFG_FAST:     fast_q <= cfg_data_i[0];
      endcase
    end
  end

  always_comb begin
    off = '0;
    if (sys_q == SYS_SAT || sys_q == SYS_CABLE) begin
      off = OFF_W'(act_srq_q) * OFF_W'(step_q[STEP_W-1:1]);
    end
    if (step_q[0]) begin
      zz_freq = act_f_q + FREQ_W'(off);
    end else begin
      zz_freq = act_f_q - FREQ_W'(off);
    end
  end

  always_comb begin
    mode_d     = mode_q;
    step_d     = step_q;
    act_f_d    = act_f_q;
    act_sr_d   = act_sr_q;
    act_srq_d  = act_srq_q;
    act_fec_d  = act_fec_q;
    act_inv_d  = act_inv_q;
    pend_f_d   = pend_f_q;
    pend_sr_d  = pend_sr_q;
    pend_srq_d = pend_srq_q;
    pend_fec_d = pend_fec_q;
    pend_inv_d = pend_inv_q;
    tuned_d    = tuned_q;
    wait_d     = wait_q;
    freq_chg   = !item_i.lock_now || (act_f_q != pend_f_q);
    front      = 1'b0;
    res_o      = '0;
    res_o.delay = wait_q;

    case (sys_q) inside
      SYS_SAT, SYS_CABLE: front = (act_sr_q != pend_sr_q) || (act_fec_q != pend_fec_q) ||
                                  (act_inv_q != pend_inv_q);
      SYS_TERR:           front = 1'b1;
      default:            front = 1'b0;
    endcase

    case (item_i.cmd)
      CMD_TUNE: begin
        pend_f_d    = item_i.freq;
        pend_sr_d   = item_i.sr;
        pend_srq_d  = sr_step(item_i.sr);
        pend_fec_d  = item_i.fec;
        pend_inv_d  = item_i.inv;
        mode_d      = MODE_TUNE;
        res_o.delay = WAIT_NOW;
      end
      CMD_STOP: begin
        if (mode_q != MODE_IDLE) begin
          mode_d      = MODE_IDLE;
          res_o.delay = WAIT_NOW;
        end
      end
      CMD_WAKE: begin
        case (mode_q)
          MODE_TUNE: begin
            res_o.fv   = freq_chg;
            res_o.fval = freq_chg ? pend_f_q : '0;
            res_o.fe   = !item_i.lock_now || front;
            res_o.rst  = freq_chg || res_o.fe;
            act_f_d    = pend_f_q;
            act_sr_d   = pend_sr_q;
            act_srq_d  = pend_srq_q;
            act_fec_d  = pend_fec_q;
            act_inv_d  = pend_inv_q;
            tuned_d    = pend_f_q;
            if (sys_q == SYS_SAT) begin
              step_d = STEP_W'(1);
            end else if (sys_q != SYS_NONE) begin
              step_d = '0;
            end
            if (item_i.lock_after) begin
              res_o.ev  = EV_DONE;
              res_o.evf = pend_f_q;
              mode_d    = MODE_WATCH;
              wait_d    = WAIT_DONE;
            end else begin
              mode_d = MODE_ZIGZAG;
              if (sys_q == SYS_SAT) begin
                wait_d = WAIT_TUNE_SAT;
              end else if (sys_q != SYS_NONE) begin
                wait_d = WAIT_TUNE;
              end
            end
          end
          MODE_ZIGZAG: begin
            if (item_i.lock_now) begin
              res_o.ev  = EV_DONE;
              res_o.evf = act_f_q;
              mode_d    = MODE_WATCH;
              wait_d    = WAIT_DONE;
            end else if (step_q >= STEP_W'(ZIGZAG_LIMIT)) begin
              res_o.fv   = 1'b1;
              res_o.fval = act_f_q;
              res_o.rst  = 1'b1;
              res_o.ev   = EV_FAIL;
              mode_d     = MODE_IDLE;
            end else begin
              res_o.fv   = 1'b1;
              res_o.fval = zz_freq;
              res_o.rst  = 1'b1;
              tuned_d    = zz_freq;
              step_d     = step_q + STEP_W'(1);
              if (sys_q == SYS_SAT) begin
                wait_d = WAIT_STEP_FAST;
              end else if (sys_q != SYS_NONE) begin
                wait_d = WAIT_STEP;
              end
              if (fast_q) begin
                wait_d = WAIT_STEP_FAST;
              end
            end
          end
          MODE_WATCH: begin
            if (!item_i.lock_now) begin
              mode_d = MODE_TUNE;
              wait_d = WAIT_RETUNE;
            end else begin
              wait_d = WAIT_WATCH;
            end
          end
          default: begin
            wait_d = WAIT_IDLE;
          end
        endcase
        res_o.delay = wait_d;
      end
      default: begin
        res_o.delay = wait_q;
      end
    endcase

    res_o.mode = mode_d;
    res_o.cur  = tuned_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      step_q     <= '0;
      act_f_q    <= '0;
      act_sr_q   <= '0;
      act_srq_q  <= '0;
      act_fec_q  <= '0;
      act_inv_q  <= '0;
      pend_f_q   <= '0;
      pend_sr_q  <= '0;
      pend_srq_q <= '0;
      pend_fec_q <= '0;
      pend_inv_q <= '0;
      tuned_q    <= '0;
      wait_q     <= WAIT_IDLE;
    end else if (advance_i) begin
      mode_q     <= mode_d;
      step_q     <= step_d;
      act_f_q    <= act_f_d;
      act_sr_q   <= act_sr_d;
      act_srq_q  <= act_srq_d;
      act_fec_q  <= act_fec_d;
      act_inv_q  <= act_inv_d;
      pend_f_q   <= pend_f_d;
      pend_sr_q  <= pend_sr_d;
      pend_srq_q <= pend_srq_d;
      pend_fec_q <= pend_fec_d;
      pend_inv_q <= pend_inv_d;
      tuned_q    <= tuned_d;
      wait_q     <= wait_d;
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(ZIGZAG_LIMIT))
    else $error("zigzag step count beyond the limit");

  a_pend_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_srq_q == sr_step(pend_sr_q))
    else $error("pending step size out of step with pending symbol rate");

  a_act_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_srq_q == sr_step(act_sr_q))
    else $error("active step size out of step with active symbol rate");

  a_idle_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.cmd == CMD_WAKE && mode_q == MODE_IDLE |=>
      wait_q == WAIT_IDLE && mode_q == MODE_IDLE)
    else $error("idle wake did not restore the idle wait");
`endif

endmodule

/* design/tuner_zigzag_lock_search_top.sv */
// Flow: an accepted request is held in the input register, passes through the core
// and is loaded into the result register, which offers it downstream.
// Throughput: one request per cycle while out_ready_i keeps the result register draining;
// the state update is a single registered pass between the input register and the result register.
// Reset: rst_ni clears both stages, selects idle mode with a 1000 ms wait,
// satellite delivery and normal demodulator timing.
// ----------------------------------------------------------------------------
// Tuner zigzag lock search top level
// Demodulator tuning sequencer with tune, zigzag search and lock watch.
// ----------------------------------------------------------------------------
module tuner_zigzag_lock_search_top
  import tzls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [FREQ_W-1:0]     new_frequency_i,
  input  logic [SR_W-1:0]       new_symbol_rate_i,
  input  logic [FEC_W-1:0]      new_fec_i,
  input  logic [INV_W-1:0]      new_inversion_i,
  input  logic                  lock_now_i,
  input  logic                  lock_after_program_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  set_freq_valid_o,
  output logic [FREQ_W-1:0]     freq_value_o,
  output logic                  set_frontend_valid_o,
  output logic                  demod_reset_o,
  output logic [1:0]            event_code_o,
  output logic [FREQ_W-1:0]     event_frequency_o,
  output logic [1:0]            mode_out_o,
  output logic [DELAY_W-1:0]    next_delay_ms_o,
  output logic [FREQ_W-1:0]     current_frequency_o
);

  in_item_t in_item;
  in_item_t core_item;
  logic     core_valid;
  logic     load_ready;
  logic     advance;
  result_t  core_res;
  result_t  out_res;

  assign in_item.cmd        = cmd_e'(command_i);
  assign in_item.freq       = new_frequency_i;
  assign in_item.sr         = new_symbol_rate_i;
  assign in_item.fec        = new_fec_i;
  assign in_item.inv        = new_inversion_i;
  assign in_item.lock_now   = lock_now_i;
  assign in_item.lock_after = lock_after_program_i;

  assign advance = core_valid && load_ready;

  tzls_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (core_valid),
    .item_o     (core_item)
  );

  tzls_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .item_i      (core_item),
    .res_o       (core_res)
  );

  tzls_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (core_valid),
    .res_i        (core_res),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (out_res)
  );

  assign set_freq_valid_o     = out_res.fv;
  assign freq_value_o         = out_res.fval;
  assign set_frontend_valid_o = out_res.fe;
  assign demod_reset_o        = out_res.rst;
  assign event_code_o         = out_res.ev;
  assign event_frequency_o    = out_res.evf;
  assign mode_out_o           = out_res.mode;
  assign next_delay_ms_o      = out_res.delay;
  assign current_frequency_o  = out_res.cur;

endmodule

/* verif/tuner_zigzag_lock_search_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner zigzag lock search testbench
// Drives tune requests, stops and timer wakes through the request handshake
// while the configuration is stepped through every delivery system and both
// demodulator timings. A directed table comes first, then random tune and
// wake sequences. Each result is compared field by field with its typed row in
// the table or the step computed by an independent tracking model of the sequencer.
// ----------------------------------------------------------------------------
module tuner_zigzag_lock_search_top_tb;
  import tzls_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS = 85;

  typedef struct packed {
    in_item_t req;
    logic     typed;
    result_t  want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            command_i;
  logic [FREQ_W-1:0]     new_frequency_i;
  logic [SR_W-1:0]       new_symbol_rate_i;
  logic [FEC_W-1:0]      new_fec_i;
  logic [INV_W-1:0]      new_inversion_i;
  logic                  lock_now_i;
  logic                  lock_after_program_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  set_freq_valid_o;
  logic [FREQ_W-1:0]     freq_value_o;
  logic                  set_frontend_valid_o;
  logic                  demod_reset_o;
  logic [1:0]            event_code_o;
  logic [FREQ_W-1:0]     event_frequency_o;
  logic [1:0]            mode_out_o;
  logic [DELAY_W-1:0]    next_delay_ms_o;
  logic [FREQ_W-1:0]     current_frequency_o;

  // Tracked sequencer state and configuration.
  mode_e              trk_mode = MODE_IDLE;
  logic [STEP_W-1:0]  trk_step = '0;
  logic [FREQ_W-1:0]  act_freq = '0;
  logic [SR_W-1:0]    act_sr = '0;
  logic [FEC_W-1:0]   act_fec = '0;
  logic [INV_W-1:0]   act_inv = '0;
  logic [FREQ_W-1:0]  pend_freq = '0;
  logic [SR_W-1:0]    pend_sr = '0;
  logic [FEC_W-1:0]   pend_fec = '0;
  logic [INV_W-1:0]   pend_inv = '0;
  logic [FREQ_W-1:0]  tuned_freq = '0;
  logic [DELAY_W-1:0] wait_now = 16'd1000;
  sys_e               cfg_sys = SYS_SAT;
  logic               cfg_fast = 1'b0;

  result_t     step_results_q[$];
  int unsigned bad_fields = 0;
  int unsigned burst_left = 12;
  logic        offering = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  tuner_zigzag_lock_search_top u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .command_i            (command_i),
    .new_frequency_i      (new_frequency_i),
    .new_symbol_rate_i    (new_symbol_rate_i),
    .new_fec_i            (new_fec_i),
    .new_inversion_i      (new_inversion_i),
    .lock_now_i           (lock_now_i),
    .lock_after_program_i (lock_after_program_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .set_freq_valid_o     (set_freq_valid_o),
    .freq_value_o         (freq_value_o),
    .set_frontend_valid_o (set_frontend_valid_o),
    .demod_reset_o        (demod_reset_o),
    .event_code_o         (event_code_o),
    .event_frequency_o    (event_frequency_o),
    .mode_out_o           (mode_out_o),
    .next_delay_ms_o      (next_delay_ms_o),
    .current_frequency_o  (current_frequency_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (bad_fields < 40) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    bad_fields++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic announce_lock(inout result_t rs);
    rs.ev = EV_DONE;
    rs.evf = act_freq;
    trk_mode = MODE_WATCH;
    wait_now = 16'd10000;
  endtask

  task automatic tuner_step(input in_item_t rq, output result_t rs);
    logic               front;
    logic [STEP_W-1:0]  idx;
    logic [FREQ_W-1:0]  off;
    logic [FREQ_W-1:0]  f;
    logic [DELAY_W-1:0] delay;
    rs = '0;
    delay = wait_now;
    case (rq.cmd)
      CMD_TUNE: begin
        pend_freq = rq.freq;
        pend_sr = rq.sr;
        pend_fec = rq.fec;
        pend_inv = rq.inv;
        trk_mode = MODE_TUNE;
        delay = 16'd0;
      end
      CMD_STOP: begin
        if (trk_mode != MODE_IDLE) begin
          trk_mode = MODE_IDLE;
          delay = 16'd0;
        end
      end
      CMD_WAKE: begin
        case (trk_mode)
          MODE_TUNE: begin
            if (!rq.lock_now || act_freq != pend_freq) begin
              rs.fv = 1'b1;
              rs.fval = pend_freq;
              rs.rst = 1'b1;
            end
            front = (cfg_sys == SYS_TERR);
            if (cfg_sys == SYS_SAT || cfg_sys == SYS_CABLE) begin
              front = act_sr != pend_sr || act_fec != pend_fec || act_inv != pend_inv;
            end
            act_freq = pend_freq;
            act_sr = pend_sr;
            act_fec = pend_fec;
            act_inv = pend_inv;
            if (!rq.lock_now || front) begin
              rs.fe = 1'b1;
              rs.rst = 1'b1;
            end
            if (cfg_sys == SYS_SAT) begin
              trk_step = 5'd1;
            end else if (cfg_sys != SYS_NONE) begin
              trk_step = 5'd0;
            end
            tuned_freq = act_freq;
            if (rq.lock_after) begin
              announce_lock(rs);
            end else begin
              trk_mode = MODE_ZIGZAG;
              if (cfg_sys == SYS_SAT) begin
                wait_now = 16'd100;
              end else if (cfg_sys != SYS_NONE) begin
                wait_now = 16'd500;
              end
            end
          end
          MODE_ZIGZAG: begin
            idx = trk_step;
            if (rq.lock_now) begin
              announce_lock(rs);
            end else if (idx >= ZIGZAG_LIMIT) begin
              rs.fv = 1'b1;
              rs.fval = act_freq;
              rs.rst = 1'b1;
              rs.ev = EV_FAIL;
              trk_mode = MODE_IDLE;
            end else begin
              off = '0;
              if (cfg_sys == SYS_SAT || cfg_sys == SYS_CABLE) begin
                off = 32'(act_sr) / 32'd16000;
              end
              off = off * 32'(idx >> 1);
              f = idx[0] ? act_freq + off : act_freq - off;
              rs.fv = 1'b1;
              rs.fval = f;
              rs.rst = 1'b1;
              tuned_freq = f;
              trk_step = idx + 5'd1;
              if (cfg_sys == SYS_SAT) begin
                wait_now = 16'd50;
              end else if (cfg_sys != SYS_NONE) begin
                wait_now = 16'd500;
              end
              if (cfg_fast) begin
                wait_now = 16'd50;
              end
            end
          end
          MODE_WATCH: begin
            if (!rq.lock_now) begin
              trk_mode = MODE_TUNE;
              wait_now = 16'd500;
            end else begin
              wait_now = 16'd60000;
            end
          end
          default: begin
            wait_now = 16'd1000;
          end
        endcase
        delay = wait_now;
      end
      default: begin
      end
    endcase
    rs.mode = trk_mode;
    rs.delay = delay;
    rs.cur = tuned_freq;
  endtask

  function automatic in_item_t req_of(input cmd_e c, input logic [FREQ_W-1:0] f,
                                      input logic [SR_W-1:0] s,
                                      input logic [FEC_W-1:0] fc,
                                      input logic [INV_W-1:0] iv,
                                      input logic l0, input logic l1);
    in_item_t rq;
    rq.cmd = c;
    rq.freq = f;
    rq.sr = s;
    rq.fec = fc;
    rq.inv = iv;
    rq.lock_now = l0;
    rq.lock_after = l1;
    return rq;
  endfunction

  function automatic result_t quiet(input mode_e m, input logic [DELAY_W-1:0] d);
    result_t rs;
    rs = '0;
    rs.mode = m;
    rs.delay = d;
    return rs;
  endfunction

  // Lock is rare during a search so that some searches run to failure.
  function automatic in_item_t draw_wake();
    logic l0;
    case (trk_mode)
      MODE_ZIGZAG: l0 = ($urandom_range(15, 0) == 0);
      MODE_WATCH:  l0 = ($urandom_range(3, 0) != 0);
      default:     l0 = 1'($urandom_range(1, 0));
    endcase
    return req_of(CMD_WAKE, $urandom, SR_W'($urandom_range(100000000, 0)),
                  FEC_W'($urandom_range(15, 0)), INV_W'($urandom_range(2, 0)), l0,
                  ($urandom_range(2, 0) == 0));
  endfunction

  function automatic in_item_t draw_tune();
    in_item_t rq;
    rq = draw_wake();
    rq.cmd = CMD_TUNE;
    case ($urandom_range(3, 0))
      0: rq.freq = $urandom;
      1: rq.freq = act_freq;
      2: rq.freq = $urandom_range(20000, 0);
      default: rq.freq = 32'hFFFF_FFFF - $urandom_range(20000, 0);
    endcase
    case ($urandom_range(6, 0))
      0: rq.sr = SR_W'($urandom_range(100000000, 0));
      1: rq.sr = act_sr;
      2: rq.sr = SR_W'($urandom_range(40000, 0));
      3: rq.sr = '0;
      4: rq.sr = 27'd16000;
      5: rq.sr = 27'd100000000;
      default: rq.sr = act_sr;
    endcase
    if ($urandom_range(1, 0) != 0) begin
      rq.fec = act_fec;
    end
    if ($urandom_range(1, 0) != 0) begin
      rq.inv = act_inv;
    end
    return rq;
  endfunction

  // Ends a burst with a random gap once its length is used up.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30) :
                                                 $urandom_range(8, 1);
    end
  endtask

  task automatic send_request(input in_item_t rq, input logic typed,
                              input result_t typed_want);
    result_t predicted;
    in_valid_i <= 1'b1;
    offering = 1'b1;
    command_i <= rq.cmd;
    new_frequency_i <= rq.freq;
    new_symbol_rate_i <= rq.sr;
    new_fec_i <= rq.fec;
    new_inversion_i <= rq.inv;
    lock_now_i <= rq.lock_now;
    lock_after_program_i <= rq.lock_after;
    do @(posedge clk_i); while (!in_ready_o);
    tuner_step(rq, predicted);
    step_results_q.push_back(typed ? typed_want : predicted);
    pace();
  endtask

  task automatic settle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic drain_results();
    while (step_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input sys_e sys, input logic fast);
    cfg_sys = sys;
    cfg_fast = fast;
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_DELIVERY;
    cfg_data_i <= sys;
    @(posedge clk_i);
    cfg_index_i <= CFG_FAST;
    cfg_data_i <= {1'b0, fast};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_run(input int count);
    int      sent;
    int      chain;
    int      k;
    in_item_t rq;
    result_t unused;
    unused = '0;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9, 0) < 8) begin
        send_request(draw_tune(), 1'b0, unused);
        sent++;
        chain = ($urandom_range(1, 0) != 0) ? $urandom_range(26, 20) :
                                              $urandom_range(8, 1);
        for (k = 0; k < chain; k++) begin
          rq = draw_wake();
          if ($urandom_range(24, 0) == 0) begin
            rq.cmd = cmd_e'($urandom_range(3, 0));
          end
          send_request(rq, 1'b0, unused);
          sent++;
        end
      end else begin
        rq = draw_wake();
        rq.cmd = cmd_e'($urandom_range(3, 0));
        send_request(rq, 1'b0, unused);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    int style;
    int span;
    int beat;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        style = $urandom_range(2, 0);
        span = $urandom_range(60, 10);
        for (beat = 0; beat < span; beat++) begin
          case (style)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(1, 0));
            default: out_ready_i <= ((beat % 5) < 2);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.fv = set_freq_valid_o;
      got.fval = freq_value_o;
      got.fe = set_frontend_valid_o;
      got.rst = demod_reset_o;
      got.ev = event_e'(event_code_o);
      got.evf = event_frequency_o;
      got.mode = mode_e'(mode_out_o);
      got.delay = next_delay_ms_o;
      got.cur = current_frequency_o;
      if (step_results_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = step_results_q.pop_front();
        compare_field("set_freq_valid", got.fv, want.fv);
        compare_field("freq_value", got.fval, want.fval);
        compare_field("set_frontend_valid", got.fe, want.fe);
        compare_field("demod_reset", got.rst, want.rst);
        compare_field("event_code", got.ev, want.ev);
        compare_field("event_frequency", got.evf, want.evf);
        compare_field("mode_out", got.mode, want.mode);
        compare_field("next_delay_ms", got.delay, want.delay);
        compare_field("current_frequency", got.cur, want.cur);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tuner_zigzag_lock_search_top_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t dir_rows [25];
    sys_e      plan_sys [8];
    logic      plan_fast [8];
    int        i;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_DELIVERY;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_NOP;
    new_frequency_i = '0;
    new_symbol_rate_i = '0;
    new_fec_i = '0;
    new_inversion_i = '0;
    lock_now_i = 1'b0;
    lock_after_program_i = 1'b0;
    plan_sys = '{SYS_SAT, SYS_CABLE, SYS_TERR, SYS_NONE,
                 SYS_SAT, SYS_CABLE, SYS_NONE, SYS_TERR};
    plan_fast = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    dir_rows[0]  = '{req_of(CMD_STOP, 0, 0, 0, 0, 0, 0), 1'b1,
                     quiet(MODE_IDLE, 16'd1000)};
    dir_rows[1]  = '{req_of(CMD_NOP, 0, 0, 0, 0, 0, 0), 1'b1,
                     quiet(MODE_IDLE, 16'd1000)};
    dir_rows[2]  = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 1), 1'b1,
                     quiet(MODE_IDLE, 16'd1000)};
    dir_rows[3]  = '{req_of(CMD_TUNE, 32'hFFFF_FFFF, 27'd100000000, 4'd15, 2'd2, 0, 0),
                     1'b1, quiet(MODE_TUNE, 16'd0)};
    dir_rows[4]  = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[5]  = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[6]  = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[7]  = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[8]  = '{req_of(CMD_NOP, 32'hFFFF_FFFF, 27'h7FF_FFFF, 4'd15, 2'd3, 1, 1),
                     1'b0, '0};
    dir_rows[9]  = '{req_of(CMD_STOP, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[10] = '{req_of(CMD_STOP, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[11] = '{req_of(CMD_TUNE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[12] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 1), 1'b0, '0};
    dir_rows[13] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 0), 1'b0, '0};
    dir_rows[14] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[15] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 1), 1'b0, '0};
    dir_rows[16] = '{req_of(CMD_TUNE, 32'h1234_5678, 27'h555_5555, 4'd10, 2'd1, 0, 0),
                     1'b0, '0};
    dir_rows[17] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 0), 1'b0, '0};
    dir_rows[18] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 0), 1'b0, '0};
    dir_rows[19] = '{req_of(CMD_TUNE, 32'h8000_0000, 27'd16000, 4'd5, 2'd0, 0, 0),
                     1'b0, '0};
    dir_rows[20] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[21] = '{req_of(CMD_TUNE, 32'h8000_0000, 27'd16000, 4'd5, 2'd0, 0, 0),
                     1'b0, '0};
    dir_rows[22] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 1, 1), 1'b0, '0};
    dir_rows[23] = '{req_of(CMD_WAKE, 0, 0, 0, 0, 0, 1), 1'b0, '0};
    dir_rows[24] = '{req_of(CMD_STOP, 0, 0, 0, 0, 0, 0), 1'b0, '0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < 25; i++) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (i = 0; i < 8; i++) begin
      settle();
      drain_results();
      apply_settings(plan_sys[i], plan_fast[i]);
      if (i == 0 || i == 4) begin
        hold_req = 1'b1;
      end
      random_run(PHASE_ITEMS);
      settle();
      drain_results();
      random_run(PHASE_ITEMS);
    end

    settle();
    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (bad_fields == 0 && step_results_q.size() == 0) begin
      $display("tuner_zigzag_lock_search_top_tb passed");
    end else begin
      $display("tuner_zigzag_lock_search_top_tb failed");
    end
    $finish;
  end

endmodule
